FILE: rtl/median_clock_offset_estimator_macros.svh
// Assertion macros shared by the median clock offset estimator RTL.
// Both macros assume a clock named clk and an active-low reset named rst_n.
`ifndef MEDIAN_CLOCK_OFFSET_ESTIMATOR_MACROS_SVH
`define MEDIAN_CLOCK_OFFSET_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MCOE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MCOE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mcoe_pkg.sv
// Shared constants and types for the median clock offset estimator.
// No dependencies; every other RTL file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mcoe_pkg;

    localparam int WINDOW_SIZE  = 10;
    localparam int MEDIAN_START = 3;

    localparam int TIME_W   = 48;
    localparam int DELAY_W  = TIME_W - 1;
    localparam int OFFSET_W = 50;
    localparam int FILL_W   = 4;

    localparam int IDX_W = $clog2(WINDOW_SIZE);
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W = OFFSET_W + $clog2(WINDOW_SIZE);

    // Serial divide of the window sum by WINDOW_SIZE, one byte per step.
    localparam int DIV_BYTES = (SUM_W + 7) / 8;
    localparam int DIVD_W    = DIV_BYTES * 8;
    localparam int REM_W     = $clog2(WINDOW_SIZE);
    localparam int RECIP_SH  = 16;
    localparam int RECIP     = (2 ** RECIP_SH + WINDOW_SIZE - 1) / WINDOW_SIZE;

    typedef logic signed [OFFSET_W-1:0] offset_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [TIME_W-1:0]          time_t;
    typedef logic [DELAY_W-1:0]         delay_t;
    typedef logic [IDX_W-1:0]           idx_t;
    typedef logic [CNT_W-1:0]           cnt_t;
    typedef logic [FILL_W-1:0]          fill_t;

    // Order statistics read back from the sorted window.
    typedef struct packed {
        offset_t med;
        offset_t mn;
        offset_t mx;
    } win_stats_t;

endpackage

`default_nettype wire

FILE: rtl/median_clock_offset_estimator.sv
// Top level of the median clock offset estimator: request handshakes, offset arithmetic,
// window bookkeeping and result register. Depends on mcoe_pkg, mcoe_window, mcoe_mean_div
// and the assertion macros header.
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  ---------------------------------------------
//   in        sink       in_valid / in_stall  send_time, server_time, receive_time,
//                                             exchange_failed
//   out       source     out_valid/out_stall  applied_offset, sample_offset, fill_count,
//                                             stats_valid, min_offset, max_offset, mean_offset
//
// One request is in flight at a time. A failed exchange goes from acceptance straight to the
// final load of the result register. A good sample first has its delay and offset registered,
// then goes through the sorted window memory, which moves the stored offsets larger than the
// new one (none to nine of them) up by one slot, one entry per cycle, writes the new offset into
// its slot and then reads the median, minimum and maximum through its single read port; on an
// empty window the new offset is written at once. The sample that completes the window then
// goes through the byte-serial divide that forms the mean.
// Reset clears the fill count, the running sum and all handshake state; the window memory
// needs no clearing because it only reads slots written since the window last started over.
// A stalled result stays in the output register; the next request is still accepted and
// worked on, and only waits at the final load until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "median_clock_offset_estimator_macros.svh"

module median_clock_offset_estimator
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire mcoe_pkg::time_t    send_time,
    input  wire mcoe_pkg::time_t    server_time,
    input  wire mcoe_pkg::time_t    receive_time,
    input  wire logic               exchange_failed,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output mcoe_pkg::offset_t       applied_offset,
    output mcoe_pkg::offset_t       sample_offset,
    output mcoe_pkg::fill_t         fill_count,
    output logic                    stats_valid,
    output mcoe_pkg::offset_t       min_offset,
    output mcoe_pkg::offset_t       max_offset,
    output mcoe_pkg::offset_t       mean_offset
);

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_DLY    = 3'd1;
    localparam logic [2:0] T_SMP    = 3'd2;
    localparam logic [2:0] T_WSTART = 3'd3;
    localparam logic [2:0] T_WWAIT  = 3'd4;
    localparam logic [2:0] T_DSTART = 3'd5;
    localparam logic [2:0] T_DWAIT  = 3'd6;
    localparam logic [2:0] T_OUT    = 3'd7;

    logic [2:0] state_reg, state_next;

    // Control state.
    mcoe_pkg::cnt_t fill_reg, fill_next;
    mcoe_pkg::sum_t sum_reg, sum_next;
    logic           out_valid_reg, out_valid_next;

    // Captured request and intermediate values.
    mcoe_pkg::time_t   snd_reg, srv_reg, rcv_reg;
    logic              failed_reg;
    mcoe_pkg::delay_t  delay_reg, delay_next;
    mcoe_pkg::offset_t sample_reg, sample_next;

    // Result register.
    mcoe_pkg::offset_t applied_reg, sample_out_reg, min_reg, max_reg, mean_reg;
    mcoe_pkg::fill_t   fill_out_reg;
    logic              stats_reg;

    logic accept, load;
    mcoe_pkg::cnt_t n_val;
    logic complete, use_median;
    logic [mcoe_pkg::TIME_W-1:0] rtt_v;

    logic                 win_start, win_done;
    mcoe_pkg::win_stats_t win_stats;
    logic                 div_start, div_done;
    mcoe_pkg::offset_t    div_quo;

    assign in_stall   = (state_reg != T_IDLE);
    assign accept     = in_valid && !in_stall;
    assign load       = (state_reg == T_OUT) && (!out_valid_reg || !out_stall);

    // Count of stored samples once this one is in.
    assign n_val      = fill_reg + mcoe_pkg::cnt_t'(1);
    assign complete   = (n_val == mcoe_pkg::cnt_t'(mcoe_pkg::WINDOW_SIZE));
    assign use_median = (n_val >= mcoe_pkg::cnt_t'(mcoe_pkg::MEDIAN_START));

    assign rtt_v      = rcv_reg - snd_reg;
    assign win_start  = (state_reg == T_WSTART);
    assign div_start  = (state_reg == T_DSTART);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        // One-way delay is half the round trip, rounded down, and zero if the reply
        // time stamp lies before the send time stamp.
        delay_next     = (rcv_reg >= snd_reg) ? rtt_v[mcoe_pkg::TIME_W-1:1] : '0;
        sample_next    = mcoe_pkg::offset_t'(srv_reg)
                       + mcoe_pkg::offset_t'(delay_reg)
                       - mcoe_pkg::offset_t'(rcv_reg);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    state_next = exchange_failed ? T_OUT : T_DLY;
                end
            end
            T_DLY:
            begin
                state_next = T_SMP;
            end
            T_SMP:
            begin
                state_next = T_WSTART;
            end
            T_WSTART:
            begin
                sum_next   = sum_reg + mcoe_pkg::sum_t'(sample_reg);
                state_next = T_WWAIT;
            end
            T_WWAIT:
            begin
                if (win_done)
                begin
                    state_next = complete ? T_DSTART : T_OUT;
                end
            end
            T_DSTART:
            begin
                state_next = T_DWAIT;
            end
            T_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                    if (!failed_reg)
                    begin
                        // A full window is reported once and then starts over empty.
                        fill_next = complete ? '0 : n_val;
                        sum_next  = complete ? '0 : sum_reg;
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            snd_reg    <= send_time;
            srv_reg    <= server_time;
            rcv_reg    <= receive_time;
            failed_reg <= exchange_failed;
        end
        delay_reg  <= delay_next;
        sample_reg <= sample_next;
        if (load)
        begin
            if (failed_reg)
            begin
                applied_reg    <= '0;
                sample_out_reg <= '0;
                fill_out_reg   <= mcoe_pkg::fill_t'(fill_reg);
                stats_reg      <= 1'b0;
                min_reg        <= '0;
                max_reg        <= '0;
                mean_reg       <= '0;
            end
            else
            begin
                applied_reg    <= use_median ? win_stats.med : sample_reg;
                sample_out_reg <= sample_reg;
                fill_out_reg   <= mcoe_pkg::fill_t'(n_val);
                stats_reg      <= complete;
                min_reg        <= complete ? win_stats.mn : '0;
                max_reg        <= complete ? win_stats.mx : '0;
                mean_reg       <= complete ? div_quo : '0;
            end
        end
    end

    mcoe_window u_window
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (win_start),
        .key   (sample_reg),
        .fill  (fill_reg),
        .done  (win_done),
        .stats (win_stats)
    );

    mcoe_mean_div u_mean_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid      = out_valid_reg;
    assign applied_offset = applied_reg;
    assign sample_offset  = sample_out_reg;
    assign fill_count     = fill_out_reg;
    assign stats_valid    = stats_reg;
    assign min_offset     = min_reg;
    assign max_offset     = max_reg;
    assign mean_offset    = mean_reg;

    `MCOE_ASSERT_NOW(a_fill_range, 1'b1, fill_reg < mcoe_pkg::cnt_t'(mcoe_pkg::WINDOW_SIZE), "fill count beyond window")
    `MCOE_ASSERT_NOW(a_stats_full, out_valid_reg && stats_reg, fill_out_reg == mcoe_pkg::fill_t'(mcoe_pkg::WINDOW_SIZE), "statistics without a full window")
    `MCOE_ASSERT_NOW(a_median_in_range, out_valid_reg && stats_reg, (min_reg <= applied_reg) && (applied_reg <= max_reg) && (min_reg <= mean_reg) && (mean_reg <= max_reg), "median or mean outside window range")
    `MCOE_ASSERT_NEXT(a_accept_busy, accept, state_reg != T_IDLE, "accepted request left no work")

endmodule

`default_nettype wire

FILE: rtl/mcoe_window.sv
// Sorted offset window: one synchronous memory kept in ascending order by insertion.
// Depends on mcoe_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "median_clock_offset_estimator_macros.svh"

module mcoe_window
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire mcoe_pkg::offset_t   key,
    input  wire mcoe_pkg::cnt_t      fill,
    output logic                     done,
    output mcoe_pkg::win_stats_t     stats
);

    localparam logic [2:0] W_IDLE = 3'd0;
    localparam logic [2:0] W_WALK = 3'd1;
    localparam logic [2:0] W_PUT  = 3'd2;
    localparam logic [2:0] W_RMED = 3'd3;
    localparam logic [2:0] W_RMIN = 3'd4;
    localparam logic [2:0] W_RMAX = 3'd5;
    localparam logic [2:0] W_REND = 3'd6;
    localparam logic [2:0] W_DONE = 3'd7;

    logic [2:0] state_reg, state_next;
    mcoe_pkg::idx_t    j_reg, j_next;
    mcoe_pkg::cnt_t    n_reg, n_next;
    mcoe_pkg::offset_t key_reg, key_next;
    mcoe_pkg::win_stats_t stats_reg, stats_next;

    mcoe_pkg::offset_t mem [mcoe_pkg::WINDOW_SIZE];
    mcoe_pkg::offset_t rd_data_reg;

    logic              wr_en, rd_en;
    mcoe_pkg::idx_t    wr_addr, rd_addr;
    mcoe_pkg::offset_t wr_data;

    mcoe_pkg::cnt_t fill_m1, n_half, n_m1;
    mcoe_pkg::idx_t j_m1, j_m2;

    assign fill_m1 = fill - mcoe_pkg::cnt_t'(1);
    assign n_half  = n_reg >> 1;
    assign n_m1    = n_reg - mcoe_pkg::cnt_t'(1);
    assign j_m1    = j_reg - mcoe_pkg::idx_t'(1);
    assign j_m2    = j_reg - mcoe_pkg::idx_t'(2);

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        key_next   = key_reg;
        stats_next = stats_reg;
        wr_en      = 1'b0;
        wr_addr    = j_reg;
        wr_data    = key_reg;
        rd_en      = 1'b0;
        rd_addr    = j_m2;
        done       = 1'b0;
        unique case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    n_next   = fill + mcoe_pkg::cnt_t'(1);
                    j_next   = fill[mcoe_pkg::IDX_W-1:0];
                    if (fill == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = key;
                        state_next = W_RMED;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = fill_m1[mcoe_pkg::IDX_W-1:0];
                        state_next = W_WALK;
                    end
                end
            end
            W_WALK:
            begin
                // The entry below slot j is in rd_data_reg; larger ones move up by one.
                wr_en = 1'b1;
                if (rd_data_reg > key_reg)
                begin
                    wr_data = rd_data_reg;
                    j_next  = j_m1;
                    if (j_reg == mcoe_pkg::idx_t'(1))
                    begin
                        state_next = W_PUT;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = j_m2;
                    end
                end
                else
                begin
                    state_next = W_RMED;
                end
            end
            W_PUT:
            begin
                wr_en      = 1'b1;
                state_next = W_RMED;
            end
            W_RMED:
            begin
                rd_en      = 1'b1;
                rd_addr    = n_half[mcoe_pkg::IDX_W-1:0];
                state_next = W_RMIN;
            end
            W_RMIN:
            begin
                stats_next.med = rd_data_reg;
                rd_en          = 1'b1;
                rd_addr        = '0;
                state_next     = W_RMAX;
            end
            W_RMAX:
            begin
                stats_next.mn = rd_data_reg;
                rd_en         = 1'b1;
                rd_addr       = n_m1[mcoe_pkg::IDX_W-1:0];
                state_next    = W_REND;
            end
            W_REND:
            begin
                stats_next.mx = rd_data_reg;
                state_next    = W_DONE;
            end
            W_DONE:
            begin
                done       = 1'b1;
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        n_reg     <= n_next;
        key_reg   <= key_next;
        stats_reg <= stats_next;
    end

    // Single write port and single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign stats = stats_reg;

    `MCOE_ASSERT_NOW(a_no_same_slot, wr_en && rd_en, wr_addr != rd_addr, "read and write hit the same slot")
    `MCOE_ASSERT_NOW(a_walk_bounds, state_reg == W_WALK, (j_reg != '0) && (mcoe_pkg::cnt_t'(j_reg) < n_reg), "walk index out of range")
    `MCOE_ASSERT_NOW(a_stats_order, done, (stats_reg.mn <= stats_reg.med) && (stats_reg.med <= stats_reg.mx), "window is not sorted")

endmodule

`default_nettype wire

FILE: rtl/mcoe_mean_div.sv
// Serial divider of the signed window sum by the window size, truncating toward zero.
// Depends on mcoe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcoe_mean_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mcoe_pkg::sum_t    dividend,
    output logic                   done,
    output mcoe_pkg::offset_t      quotient
);

    localparam int X_W    = mcoe_pkg::REM_W + 8;
    localparam int PROD_W = X_W + mcoe_pkg::RECIP_SH + 1;
    localparam int DCNT_W = $clog2(mcoe_pkg::DIV_BYTES + 1);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_SIGN = 2'd2;
    localparam logic [1:0] D_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [mcoe_pkg::DIVD_W-1:0] mag_reg, mag_next, quo_reg, quo_next, quo_neg;
    logic [mcoe_pkg::REM_W-1:0] rem_reg, rem_next;
    logic neg_reg, neg_next;
    mcoe_pkg::offset_t res_reg, res_next;
    mcoe_pkg::sum_t abs_v;

    logic [X_W-1:0]    x_v, qw_v, r_v;
    logic [PROD_W-1:0] prod_v;
    logic [7:0]        q_v;

    // One byte of the magnitude per step: the partial remainder stays below the divisor,
    // so the quotient byte comes from a reciprocal multiply that is exact on this range.
    assign abs_v   = dividend[mcoe_pkg::SUM_W-1] ? -dividend : dividend;
    assign x_v     = {rem_reg, mag_reg[mcoe_pkg::DIVD_W-1 -: 8]};
    assign prod_v  = PROD_W'(x_v) * PROD_W'(mcoe_pkg::RECIP);
    assign q_v     = prod_v[mcoe_pkg::RECIP_SH +: 8];
    assign qw_v    = X_W'(q_v) * X_W'(mcoe_pkg::WINDOW_SIZE);
    assign r_v     = x_v - qw_v;
    assign quo_neg = -quo_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        done       = 1'b0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next   = dividend[mcoe_pkg::SUM_W-1];
                    mag_next   = mcoe_pkg::DIVD_W'($unsigned(abs_v));
                    quo_next   = '0;
                    rem_next   = '0;
                    cnt_next   = DCNT_W'(mcoe_pkg::DIV_BYTES);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                mag_next = mag_reg << 8;
                quo_next = {quo_reg[mcoe_pkg::DIVD_W-9:0], q_v};
                rem_next = r_v[mcoe_pkg::REM_W-1:0];
                cnt_next = cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1))
                begin
                    state_next = D_SIGN;
                end
            end
            D_SIGN:
            begin
                res_next   = neg_reg ? quo_neg[mcoe_pkg::OFFSET_W-1:0]
                                     : quo_reg[mcoe_pkg::OFFSET_W-1:0];
                state_next = D_DONE;
            end
            D_DONE:
            begin
                done       = 1'b1;
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign quotient = res_reg;

endmodule

`default_nettype wire

FILE: tb/median_clock_offset_estimator_tb.sv
// Self-checking testbench for median_clock_offset_estimator: time-exchange requests go in,
// and every result is checked against an in-bench model of the offset window.
// Depends on mcoe_pkg and the median_clock_offset_estimator RTL.
`timescale 1ns / 1ps

module median_clock_offset_estimator_tb;

    typedef struct {
        mcoe_pkg::time_t send;
        mcoe_pkg::time_t server;
        mcoe_pkg::time_t receive;
        logic            failed;
    } exchange_t;

    typedef struct {
        mcoe_pkg::offset_t applied;
        mcoe_pkg::offset_t sample;
        mcoe_pkg::fill_t   fill;
        logic              stats;
        mcoe_pkg::offset_t lowest;
        mcoe_pkg::offset_t highest;
        mcoe_pkg::offset_t mean;
    } offset_report_t;

    localparam mcoe_pkg::time_t TIME_MAX = {mcoe_pkg::TIME_W{1'b1}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    mcoe_pkg::time_t   send_time = '0;
    mcoe_pkg::time_t   server_time = '0;
    mcoe_pkg::time_t   receive_time = '0;
    logic              exchange_failed = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    mcoe_pkg::offset_t applied_offset;
    mcoe_pkg::offset_t sample_offset;
    mcoe_pkg::fill_t   fill_count;
    logic              stats_valid;
    mcoe_pkg::offset_t min_offset;
    mcoe_pkg::offset_t max_offset;
    mcoe_pkg::offset_t mean_offset;

    exchange_t      pending_exchanges[$];
    offset_report_t expected_reports[$];
    longint         window_offsets[mcoe_pkg::WINDOW_SIZE];
    int             window_count = 0;
    int             accepted_count = 0;
    int             mismatch_count = 0;
    logic           request_taken = 1'b0;
    logic           hold_results = 1'b0;
    logic           calm_stretch;

    median_clock_offset_estimator dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .send_time       (send_time),
        .server_time     (server_time),
        .receive_time    (receive_time),
        .exchange_failed (exchange_failed),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .applied_offset  (applied_offset),
        .sample_offset   (sample_offset),
        .fill_count      (fill_count),
        .stats_valid     (stats_valid),
        .min_offset      (min_offset),
        .max_offset      (max_offset),
        .mean_offset     (mean_offset)
    );

    always #5 clk = ~clk;

    // Neither side idles for a few hundred requests in the middle of the run.
    assign calm_stretch = (accepted_count >= 900) && (accepted_count < 1200);

    // Updates the window model with one exchange and returns the result it must produce.
    function automatic offset_report_t estimate_offsets(exchange_t ex);
        offset_report_t r;
        longint         snd;
        longint         srv;
        longint         rcv;
        longint         delay;
        longint         sample;
        longint         pick;
        longint         lowest;
        longint         highest;
        longint         total;
        longint         key;
        longint         ordered[mcoe_pkg::WINDOW_SIZE];
        int             j;
        r = '{default: '0};
        if (window_count >= mcoe_pkg::WINDOW_SIZE)
        begin
            window_count = 0;
        end
        if (ex.failed)
        begin
            r.fill = mcoe_pkg::fill_t'(window_count);
            return r;
        end
        snd = {16'd0, ex.send};
        srv = {16'd0, ex.server};
        rcv = {16'd0, ex.receive};
        delay = (rcv >= snd) ? (rcv - snd) / 2 : 0;
        sample = srv + delay - rcv;
        window_offsets[window_count] = sample;
        window_count++;
        pick = sample;
        if (window_count >= mcoe_pkg::MEDIAN_START)
        begin
            // Insertion sort of the held entries; the upper median is entry n/2.
            for (int i = 0; i < window_count; i++)
            begin
                key = window_offsets[i];
                j = i;
                while (j > 0 && ordered[j - 1] > key)
                begin
                    ordered[j] = ordered[j - 1];
                    j--;
                end
                ordered[j] = key;
            end
            pick = ordered[window_count / 2];
        end
        r.applied = pick[mcoe_pkg::OFFSET_W-1:0];
        r.sample  = sample[mcoe_pkg::OFFSET_W-1:0];
        r.fill    = mcoe_pkg::fill_t'(window_count);
        if (window_count >= mcoe_pkg::WINDOW_SIZE)
        begin
            lowest = window_offsets[0];
            highest = window_offsets[0];
            total = 0;
            for (int i = 0; i < window_count; i++)
            begin
                total += window_offsets[i];
                if (window_offsets[i] < lowest)
                begin
                    lowest = window_offsets[i];
                end
                if (window_offsets[i] > highest)
                begin
                    highest = window_offsets[i];
                end
            end
            total = total / mcoe_pkg::WINDOW_SIZE;
            r.stats   = 1'b1;
            r.lowest  = lowest[mcoe_pkg::OFFSET_W-1:0];
            r.highest = highest[mcoe_pkg::OFFSET_W-1:0];
            r.mean    = total[mcoe_pkg::OFFSET_W-1:0];
            window_count = 0;
        end
        return r;
    endfunction

    function automatic void check_field(string field, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic mcoe_pkg::time_t rand_time();
        return mcoe_pkg::time_t'({$urandom(), $urandom()});
    endfunction

    task automatic queue_exchange(mcoe_pkg::time_t snd, mcoe_pkg::time_t srv,
                                  mcoe_pkg::time_t rcv, logic failed);
        exchange_t ex;
        ex.send = snd;
        ex.server = srv;
        ex.receive = rcv;
        ex.failed = failed;
        pending_exchanges = {pending_exchanges, ex};
    endtask

    // Request driver: a new request is offered only once the last one was taken.
    always @(negedge clk)
    begin : feed_requests
        exchange_t ex;
        if (rst_n && (!in_valid || request_taken))
        begin
            if (pending_exchanges.size() != 0 && (calm_stretch || $urandom_range(0, 99) >= 20))
            begin
                ex = pending_exchanges.pop_front();
                in_valid        <= 1'b1;
                send_time       <= ex.send;
                server_time     <= ex.server;
                receive_time    <= ex.receive;
                exchange_failed <= ex.failed;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side stall: random, low through the calm stretch, forced high during the long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= hold_results || (!calm_stretch && $urandom_range(0, 99) < 20);
        end
    end

    // Monitor: predicts each accepted request and checks each accepted result.
    always @(posedge clk)
    begin : watch_channels
        exchange_t      ex;
        offset_report_t want;
        if (rst_n)
        begin
            request_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                ex.send = send_time;
                ex.server = server_time;
                ex.receive = receive_time;
                ex.failed = exchange_failed;
                expected_reports = {expected_reports, estimate_offsets(ex)};
                accepted_count <= accepted_count + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result with no request outstanding: applied_offset %0d",
                           applied_offset);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("applied_offset", want.applied, applied_offset);
                    check_field("sample_offset", want.sample, sample_offset);
                    check_field("fill_count", want.fill, fill_count);
                    check_field("stats_valid", want.stats, stats_valid);
                    check_field("min_offset", want.lowest, min_offset);
                    check_field("max_offset", want.highest, max_offset);
                    check_field("mean_offset", want.mean, mean_offset);
                end
            end
        end
    end

    // Long hold-off on results while requests keep coming, so the block backs up.
    initial
    begin
        wait (accepted_count >= 300);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (400) @(posedge clk);
        hold_results <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("median_clock_offset_estimator test failed");
        $finish;
    end

    initial
    begin : stimulus
        mcoe_pkg::time_t base;
        int              rtt;
        longint          skew;
        int              pick;
        // Directed part. A failed exchange on an empty window comes first.
        queue_exchange(TIME_MAX, TIME_MAX, TIME_MAX, 1'b1);
        queue_exchange('0, '0, '0, 1'b0);
        // Largest positive offset, then largest negative offset.
        queue_exchange('0, TIME_MAX, '0, 1'b0);
        queue_exchange(TIME_MAX, '0, TIME_MAX, 1'b0);
        // Receive before send, so the delay is zero.
        queue_exchange(TIME_MAX, 48'd12345, '0, 1'b0);
        // Largest round trip with both server extremes.
        queue_exchange('0, '0, TIME_MAX, 1'b0);
        queue_exchange('0, TIME_MAX, TIME_MAX, 1'b0);
        queue_exchange(rand_time(), rand_time(), rand_time(), 1'b1);
        // Odd round trip rounds the delay down.
        queue_exchange(48'd1, 48'd100, 48'd4, 1'b0);
        // Equal offsets, then the sample that completes the window.
        queue_exchange(48'd1000, 48'd1010, 48'd1020, 1'b0);
        queue_exchange(48'd2000, 48'd2010, 48'd2020, 1'b0);
        queue_exchange(48'd3000, 48'd3010, 48'd3020, 1'b0);
        // Right after the window clears.
        queue_exchange(TIME_MAX, '0, '0, 1'b1);
        queue_exchange(48'd10, 48'd5, 48'd30, 1'b0);
        queue_exchange(48'd10, 48'd50, 48'd30, 1'b0);
        queue_exchange(48'd10, 48'd50, 48'd30, 1'b0);
        queue_exchange('0, TIME_MAX, '0, 1'b0);
        queue_exchange(TIME_MAX, '0, TIME_MAX, 1'b0);
        queue_exchange(TIME_MAX, TIME_MAX, '0, 1'b0);
        queue_exchange('0, TIME_MAX, '0, 1'b0);
        queue_exchange('0, TIME_MAX, '0, 1'b0);
        queue_exchange('0, TIME_MAX, '0, 1'b0);
        queue_exchange('0, TIME_MAX, '0, 1'b0);

        // Random part: mostly plausible exchanges, with failures, ties and wild values.
        for (int i = 0; i < 1800; i++)
        begin
            pick = $urandom_range(0, 99);
            base = rand_time();
            rtt = $urandom_range(0, 4000);
            skew = longint'($urandom_range(0, 2 ** 21)) - 2 ** 20;
            if (pick < 10)
            begin
                queue_exchange(rand_time(), rand_time(), rand_time(), 1'b1);
            end
            else if (pick < 22)
            begin
                queue_exchange(rand_time(), rand_time(), rand_time(), 1'b0);
            end
            else if (pick < 30)
            begin
                queue_exchange(base, rand_time(),
                               base - mcoe_pkg::time_t'($urandom_range(1, 1000)), 1'b0);
            end
            else if (pick < 40)
            begin
                // Offsets drawn from a tiny set, so the window holds duplicates.
                skew = 5 * (longint'($urandom_range(0, 2)) - 1);
                queue_exchange(base, base + mcoe_pkg::time_t'(rtt) + mcoe_pkg::time_t'(skew),
                               base + mcoe_pkg::time_t'(2 * rtt), 1'b0);
            end
            else
            begin
                queue_exchange(base,
                               base + mcoe_pkg::time_t'(rtt / 2) + mcoe_pkg::time_t'(skew),
                               base + mcoe_pkg::time_t'(rtt), 1'b0);
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_exchanges.size() == 0 && !in_valid);
        wait (expected_reports.size() == 0);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("median_clock_offset_estimator test passed");
        end
        else
        begin
            $display("median_clock_offset_estimator test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/mcoe_pkg.sv
rtl/mcoe_window.sv
rtl/mcoe_mean_div.sv
rtl/median_clock_offset_estimator.sv
tb/median_clock_offset_estimator_tb.sv
